### rtl/task_ready_list_defines.svh
// assertion macros for the task ready list
`ifndef TASK_READY_LIST_DEFINES_SVH
`define TASK_READY_LIST_DEFINES_SVH

`ifndef ASSERT_OFF

// checked only while the block is out of reset
`define TRL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TRL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define TRL_ASSERT(lbl, prop, msg)
`define TRL_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### rtl/trl_pkg.sv
`default_nettype none

package trl_pkg;

    // list geometry
    localparam int NUM_TASKS = 32;
    localparam int TASK_W    = $clog2(NUM_TASKS);
    localparam int LINK_W    = TASK_W + 1;

    // link value for "none" and head or tail value for "empty"
    localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(NUM_TASKS);

    // requested action
    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // stream widths
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 24;

    // controller states
    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

### rtl/task_ready_list.sv
// task ready list: append or remove a task, report head, tail, count and refusal
// result is registered: the request is captured on input transfer and the result
// register is loaded on commit, which waits while an earlier result is held unread
// one item at a time, set by the read then write of the link memories
// reset (i_rst_n low, synchronous): list empty, membership bits and count cleared,
// no result pending; link memories are not cleared and take items right after reset
`default_nettype none

module task_ready_list
    import trl_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,  // task_number[4:0], zero fill
    input  wire logic [S_TUSER_W-1:0] i_s_tuser,  // action[0]
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [M_TDATA_W-1:0]      o_m_tdata   // head_task, tail_task, task_count,
                                                  // refused, zero fill
);

    t_cmd              cmd;
    t_status           status;
    logic [LINK_W-1:0] head_task;
    logic [LINK_W-1:0] tail_task;
    logic [LINK_W-1:0] task_count;
    logic              refused;

    // sequencing of one item at a time
    trl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // links, list state and result register
    trl_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_action     (i_s_tuser[0]),
        .i_task       (i_s_tdata[TASK_W-1:0]),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_m_tready   (i_m_tready),
        .o_m_tvalid   (o_m_tvalid),
        .o_head_task  (head_task),
        .o_tail_task  (tail_task),
        .o_task_count (task_count),
        .o_refused    (refused)
    );

    // pack result fields from the lowest bit up
    assign o_m_tdata = {{(M_TDATA_W - 3*LINK_W - 1){1'b0}},
                        refused, task_count, tail_task, head_task};

endmodule

`default_nettype wire

### rtl/trl_ctrl.sv
`default_nettype none

module trl_ctrl
    import trl_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_s_tready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            S_EXEC: begin
                o_cmd.commit = i_status.out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/trl_datapath.sv
`default_nettype none

`include "task_ready_list_defines.svh"

module trl_datapath
    import trl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_action,
    input  wire logic [TASK_W-1:0] i_task,
    input  wire t_cmd              i_cmd,
    output t_status                o_status,
    input  wire logic              i_m_tready,
    output logic                   o_m_tvalid,
    output logic [LINK_W-1:0]      o_head_task,
    output logic [LINK_W-1:0]      o_tail_task,
    output logic [LINK_W-1:0]      o_task_count,
    output logic                   o_refused
);

    // link memories, entries only meaningful for listed tasks
    logic [LINK_W-1:0] mem_next [NUM_TASKS];
    logic [LINK_W-1:0] mem_prev [NUM_TASKS];

    // captured request and registered link reads
    logic              r_action;
    logic [TASK_W-1:0] r_task;
    logic [LINK_W-1:0] r_rd_next;
    logic [LINK_W-1:0] r_rd_prev;

    // list state
    logic [NUM_TASKS-1:0] r_member;
    logic [LINK_W-1:0]    r_head;
    logic [LINK_W-1:0]    r_tail;
    logic [LINK_W-1:0]    r_count;
    logic [NUM_TASKS-1:0] n_member;
    logic [LINK_W-1:0]    n_head;
    logic [LINK_W-1:0]    n_tail;
    logic [LINK_W-1:0]    n_count;

    // result register
    logic              r_out_valid;
    logic [LINK_W-1:0] r_out_head;
    logic [LINK_W-1:0] r_out_tail;
    logic [LINK_W-1:0] r_out_count;
    logic              r_out_refused;

    // link update work
    logic              is_member;
    logic              do_append;
    logic              do_remove;
    logic [LINK_W-1:0] task_link;
    logic [LINK_W-1:0] nx;
    logic [LINK_W-1:0] pv;
    logic              w_next_en;
    logic [TASK_W-1:0] w_next_addr;
    logic [LINK_W-1:0] w_next_data;
    logic              w_prev_en;
    logic [TASK_W-1:0] w_prev_addr;
    logic [LINK_W-1:0] w_prev_data;

    // capture request and read its links on input transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action  <= i_action;
            r_task    <= i_task;
            r_rd_next <= mem_next[i_task];
            r_rd_prev <= mem_prev[i_task];
        end
    end

    // tail has no next and head has no prev, whatever the memory holds
    always_comb begin
        task_link = {1'b0, r_task};
        is_member = r_member[r_task];
        do_append = (r_action == ACT_APPEND) && !is_member;
        do_remove = (r_action == ACT_REMOVE) && is_member;
        nx        = (r_tail == task_link) ? NONE_LINK : r_rd_next;
        pv        = (r_head == task_link) ? NONE_LINK : r_rd_prev;
    end

    // next list state and link writes
    always_comb begin
        n_member    = r_member;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        w_next_en   = 1'b0;
        w_next_addr = r_tail[TASK_W-1:0];
        w_next_data = task_link;
        w_prev_en   = 1'b0;
        w_prev_addr = r_task;
        w_prev_data = r_tail;
        if (do_append) begin
            if (r_head == NONE_LINK) begin
                n_head = task_link;
            end else begin
                w_next_en = 1'b1;
            end
            w_prev_en        = 1'b1;
            n_tail           = task_link;
            n_member[r_task] = 1'b1;
            n_count          = r_count + LINK_W'(1);
        end else if (do_remove) begin
            if (r_head == task_link) begin
                n_head = nx;
            end
            if (r_tail == task_link) begin
                n_tail = pv;
            end
            // neighbors bypass the removed task
            if (nx != NONE_LINK) begin
                w_prev_en   = 1'b1;
                w_prev_addr = nx[TASK_W-1:0];
                w_prev_data = pv;
            end
            if (pv != NONE_LINK) begin
                w_next_en   = 1'b1;
                w_next_addr = pv[TASK_W-1:0];
                w_next_data = nx;
            end
            n_member[r_task] = 1'b0;
            if (r_count != '0) begin
                n_count = r_count - LINK_W'(1);
            end
        end
    end

    // link memory writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_next_en) begin
            mem_next[w_next_addr] <= w_next_data;
        end
        if (i_cmd.commit && w_prev_en) begin
            mem_prev[w_prev_addr] <= w_prev_data;
        end
    end

    // list state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_member <= '0;
            r_head   <= NONE_LINK;
            r_tail   <= NONE_LINK;
            r_count  <= '0;
        end else if (i_cmd.commit) begin
            r_member <= n_member;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_head    <= n_head;
            r_out_tail    <= n_tail;
            r_out_count   <= n_count;
            r_out_refused <= !(do_append || do_remove);
        end
    end

    assign o_status.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid        = r_out_valid;
    assign o_head_task       = r_out_head;
    assign o_tail_task       = r_out_tail;
    assign o_task_count      = r_out_count;
    assign o_refused         = r_out_refused;

    // list bookkeeping stays consistent
    `TRL_ASSERT(a_count_range, (r_count <= LINK_W'(NUM_TASKS)), "task count beyond list size")
    `TRL_ASSERT(a_count_members, ($countones(r_member) == int'(r_count)), "count differs from members")
    `TRL_ASSERT(a_empty_head, ((r_count == '0) == (r_head == NONE_LINK)), "head and count disagree")
    `TRL_ASSERT(a_empty_tail, ((r_head == NONE_LINK) == (r_tail == NONE_LINK)), "head and tail disagree")
    `TRL_ASSERT_ALWAYS(a_commit_room, (!i_cmd.commit || !r_out_valid || i_m_tready), "result overwritten")

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import trl_pkg::*;

    // run limits
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_MAX   = 10;

    // one reported list view, unpacked field by field from o_m_tdata
    typedef struct packed {
        logic [LINK_W-1:0] head;
        logic [LINK_W-1:0] tail;
        logic [LINK_W-1:0] count;
        logic              refused;
    } t_list_view;

    logic                 i_clk;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;  // task_number[4:0], zero fill
    logic [S_TUSER_W-1:0] i_s_tuser  = '0;  // action[0]
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;        // head, tail, count, refused, zero fill

    // predicted list state
    logic [LINK_W-1:0] next_q [NUM_TASKS];
    logic [LINK_W-1:0] prev_q [NUM_TASKS];
    logic [NUM_TASKS-1:0] member_q;
    logic [LINK_W-1:0] head_q;
    logic [LINK_W-1:0] tail_q;
    logic [LINK_W-1:0] count_q;

    // list views still owed by the block, oldest first
    t_list_view pending_views[$];

    int gap_pct   = 0;
    int stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    task_ready_list u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // list state after reset
    initial begin
        for (int i = 0; i < NUM_TASKS; i++) begin
            next_q[i] = NONE_LINK;
            prev_q[i] = NONE_LINK;
        end
        member_q = '0;
        head_q   = NONE_LINK;
        tail_q   = NONE_LINK;
        count_q  = '0;
    end

    // apply one request to the predicted list and return the view it reports
    function automatic t_list_view apply_request(input logic act,
                                                 input logic [TASK_W-1:0] tn);
        t_list_view        view;
        logic [LINK_W-1:0] nx;
        logic [LINK_W-1:0] pv;
        view.refused = 1'b1;
        if (act == ACT_APPEND && !member_q[tn]) begin
            if (head_q == NONE_LINK) begin
                head_q     = LINK_W'(tn);
                prev_q[tn] = NONE_LINK;
            end else begin
                if (tail_q < NUM_TASKS)
                    next_q[tail_q[TASK_W-1:0]] = LINK_W'(tn);
                prev_q[tn] = tail_q;
            end
            next_q[tn]   = NONE_LINK;
            tail_q       = LINK_W'(tn);
            member_q[tn] = 1'b1;
            count_q      = count_q + LINK_W'(1);
            view.refused = 1'b0;
        end else if (act == ACT_REMOVE && member_q[tn]) begin
            nx = next_q[tn];
            pv = prev_q[tn];
            if (head_q == LINK_W'(tn))
                head_q = nx;
            if (tail_q == LINK_W'(tn))
                tail_q = pv;
            if (nx < NUM_TASKS)
                prev_q[nx[TASK_W-1:0]] = pv;
            if (pv < NUM_TASKS)
                next_q[pv[TASK_W-1:0]] = nx;
            next_q[tn]   = NONE_LINK;
            prev_q[tn]   = NONE_LINK;
            member_q[tn] = 1'b0;
            if (count_q > 0)
                count_q = count_q - LINK_W'(1);
            view.refused = 1'b0;
        end
        view.head  = head_q;
        view.tail  = tail_q;
        view.count = count_q;
        return view;
    endfunction

    // send one request; tvalid stays high for a following request
    task automatic send_request(input logic act, input logic [TASK_W-1:0] tn);
        while ($urandom_range(99) < gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= S_TDATA_W'(tn);
        i_s_tuser  <= act;
        do @(posedge i_clk); while (!o_s_tready);
        pending_views.push_back(apply_request(act, tn));
    endtask

    // receiver stalls
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // compare each result transfer with the oldest predicted view
    always @(posedge i_clk) begin
        t_list_view got;
        t_list_view want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.head    = o_m_tdata[LINK_W-1:0];
            got.tail    = o_m_tdata[2*LINK_W-1:LINK_W];
            got.count   = o_m_tdata[3*LINK_W-1:2*LINK_W];
            got.refused = o_m_tdata[3*LINK_W];
            if (pending_views.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result transfer: head %0d tail %0d count %0d ref %0b",
                             got.head, got.tail, got.count, got.refused);
            end else begin
                want = pending_views.pop_front();
                if (got.head !== want.head || got.tail !== want.tail ||
                    got.count !== want.count || got.refused !== want.refused) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("mismatch: expected head %0d tail %0d count %0d ref %0b",
                                 want.head, want.tail, want.count, want.refused);
                        $display("          got      head %0d tail %0d count %0d ref %0b",
                                 got.head, got.tail, got.count, got.refused);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // extremes, refusals, and unlinking from head, middle and tail
    task automatic test_directed();
        send_request(ACT_APPEND, 5'd0);
        send_request(ACT_APPEND, 5'd31);
        send_request(ACT_APPEND, 5'd0);    // duplicate insert
        send_request(ACT_REMOVE, 5'd7);    // absent remove
        send_request(ACT_APPEND, 5'd16);
        send_request(ACT_APPEND, 5'd1);
        send_request(ACT_REMOVE, 5'd16);   // middle
        send_request(ACT_REMOVE, 5'd31);   // middle
        send_request(ACT_REMOVE, 5'd1);    // tail
        send_request(ACT_REMOVE, 5'd0);    // last one, list empties
        send_request(ACT_REMOVE, 5'd0);    // remove from empty list
        send_request(ACT_APPEND, 5'd21);
        send_request(ACT_APPEND, 5'd10);
        send_request(ACT_REMOVE, 5'd21);   // head with successor
        send_request(ACT_APPEND, 5'd21);
        send_request(ACT_APPEND, 5'd21);   // duplicate at tail
        send_request(ACT_REMOVE, 5'd21);   // tail with predecessor
        send_request(ACT_REMOVE, 5'd10);
        send_request(ACT_APPEND, 5'd31);   // reuse after removal
        send_request(ACT_REMOVE, 5'd31);
    endtask

    // fill the list completely in random order, then drain it in another
    task automatic test_fill_drain();
        int order[NUM_TASKS];
        int j;
        int tmp;
        for (int pass = 0; pass < 2; pass++) begin
            for (int i = 0; i < NUM_TASKS; i++)
                order[i] = i;
            for (int i = NUM_TASKS - 1; i > 0; i--) begin
                j        = $urandom_range(i);
                tmp      = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            for (int i = 0; i < NUM_TASKS; i++)
                send_request(pass == 0 ? ACT_APPEND : ACT_REMOVE, order[i][TASK_W-1:0]);
            // refused request on a full or empty list
            send_request(pass == 0 ? ACT_APPEND : ACT_REMOVE, order[0][TASK_W-1:0]);
        end
    endtask

    // mostly accepted requests steering the length toward a moving target
    task automatic test_random_mix(input int n_items);
        logic              act;
        logic [TASK_W-1:0] tn;
        int                target;
        target = 0;
        for (int i = 0; i < n_items; i++) begin
            if (i % 40 == 0)
                target = $urandom_range(NUM_TASKS);
            if ($urandom_range(99) < 15) begin
                act = 1'($urandom_range(1));
                tn  = TASK_W'($urandom_range(NUM_TASKS - 1));
            end else begin
                if (count_q < target || count_q == 0)
                    act = ACT_APPEND;
                else if (count_q > target || count_q == NUM_TASKS)
                    act = ACT_REMOVE;
                else
                    act = 1'($urandom_range(1));
                do tn = TASK_W'($urandom_range(NUM_TASKS - 1));
                while (member_q[tn] != (act == ACT_REMOVE));
            end
            send_request(act, tn);
        end
    endtask

    // stimulus sequence
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gap_pct   = 7;
        stall_pct = 48;
        test_directed();
        test_fill_drain();
        test_random_mix(650);

        gap_pct   = 48;
        stall_pct = 7;
        test_fill_drain();
        test_random_mix(650);

        gap_pct   = 0;
        stall_pct = 0;
        test_random_mix(650);

        // wait for every owed result, then let the block drain
        i_s_tvalid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/trl_pkg.sv
rtl/trl_ctrl.sv
rtl/trl_datapath.sv
rtl/task_ready_list.sv
verif/tb_top.sv
